// ----- design/aet_pkg.sv -----
// shared types and constants for the arithmetic expression tokenizer
// no dependencies; used by aet_scan and arith_expression_tokenizer
package aet_pkg;

  localparam int VALUE_BITS = 31;
  localparam int LINE_BITS  = 32;
  localparam int KIND_BITS  = 3;
  localparam int CHAR_BITS  = 8;

  localparam int IN_DATA_BITS  = ((CHAR_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = KIND_BITS + VALUE_BITS + LINE_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INT   = 3'd0,
    KIND_PLUS  = 3'd1,
    KIND_MINUS = 3'd2,
    KIND_STAR  = 3'd3,
    KIND_SLASH = 3'd4,
    KIND_END   = 3'd5,
    KIND_BAD   = 3'd6
  } kind_e;

  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_BITS-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_BITS-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;

  typedef struct packed {
    kind_e                 kind;
    logic [VALUE_BITS-1:0] value;
    logic [LINE_BITS-1:0]  line;
    logic                  last;
  } token_t;

endpackage

// ----- design/aet_scan.sv -----
// scanner core: number, line and halt state, up to two tokens per item
// depends on aet_pkg
module aet_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  logic [aet_pkg::CHAR_BITS-1:0] char_i,
  input  logic                      end_i,
  output aet_pkg::token_t           tok0_o,
  output aet_pkg::token_t           tok1_o,
  output logic [1:0]                count_o
);
  import aet_pkg::*;

  localparam int WIDE_BITS = VALUE_BITS + 4;

  logic                  number_active_q, number_active_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [LINE_BITS-1:0]  line_q, line_d;
  logic                  halted_q, halted_d;

  logic                  is_digit, is_blank;
  logic [WIDE_BITS-1:0]  acc_base, acc_wide;
  logic [VALUE_BITS-1:0] acc_next;
  kind_e                 op_kind;
  token_t                int_tok, op_tok;

  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign is_blank = (char_i == CH_SPACE) || ((char_i >= CH_TAB) && (char_i <= CH_CR));

  // acc * 10 + digit as two shifts and adds; saturate on any carry out
  assign acc_base = number_active_q ? {4'b0, acc_q} : '0;
  assign acc_wide = (acc_base << 3) + (acc_base << 1)
                  + WIDE_BITS'(char_i - CH_ZERO);
  assign acc_next = (acc_wide[WIDE_BITS-1:VALUE_BITS] != '0) ? '1
                                                             : acc_wide[VALUE_BITS-1:0];

  always_comb begin
    case (char_i)
      CH_PLUS:  op_kind = KIND_PLUS;
      CH_MINUS: op_kind = KIND_MINUS;
      CH_STAR:  op_kind = KIND_STAR;
      CH_SLASH: op_kind = KIND_SLASH;
      default:  op_kind = KIND_BAD;
    endcase
  end

  always_comb begin
    int_tok       = '0;
    int_tok.kind  = KIND_INT;
    int_tok.value = acc_q;
    int_tok.line  = line_q;
    op_tok        = '0;
    op_tok.kind   = end_i ? KIND_END : op_kind;
    op_tok.line   = line_q;
    op_tok.last   = 1'b1;
  end

  always_comb begin
    number_active_d = number_active_q;
    acc_d           = acc_q;
    line_d          = line_q;
    halted_d        = halted_q;
    tok0_o          = op_tok;
    tok1_o          = op_tok;
    count_o         = 2'd0;
    if (!halted_q) begin
      if (!end_i && is_digit) begin
        number_active_d = 1'b1;
        acc_d           = acc_next;
      end else begin
        number_active_d = 1'b0;
        acc_d           = '0;
        if (!end_i && is_blank) begin
          if (char_i == CH_NL) begin
            line_d = line_q + 1'b1;
          end
          // pending number alone closes the run
          if (number_active_q) begin
            tok0_o      = int_tok;
            tok0_o.last = 1'b1;
            count_o     = 2'd1;
          end
        end else begin
          if (!end_i && op_kind == KIND_BAD) begin
            halted_d = 1'b1;
          end
          if (number_active_q) begin
            tok0_o  = int_tok;
            count_o = 2'd2;
          end else begin
            count_o = 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_active_q <= 1'b0;
      acc_q           <= '0;
      line_q          <= LINE_BITS'(1);
      halted_q        <= 1'b0;
    end else if (take_i) begin
      number_active_q <= number_active_d;
      acc_q           <= acc_d;
      line_q          <= line_d;
      halted_q        <= halted_d;
    end
  end

endmodule

// ----- design/arith_expression_tokenizer.sv -----
// Arithmetic expression tokenizer. One character (or an end mark on tlast) enters per
// item; each item is scanned in the cycle it is accepted and its zero, one or two tokens
// land in a two-slot result register. Items that cause at most one token stream at one
// per clock while the receiver is ready; an item that ends a number and also yields its
// own token holds the input off until only the second token is left to drain. Integers
// saturate at all ones, newlines count lines from 1, and an unrecognized byte emits an
// error token and stops all output until reset.
// depends on aet_pkg and aet_scan
module arith_expression_tokenizer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [aet_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,  // char_code
  input  logic                              s_axis_tlast,  // end_of_input
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [aet_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,  // token_kind, token_value, line_number
  output logic                              m_axis_tlast   // last_of_run
);
  import aet_pkg::*;

  token_t     tok0, tok1;
  logic [1:0] count;
  logic       take, pop;

  token_t     head_q, head_d, tail_q, tail_d;
  logic [1:0] cnt_q, cnt_d;

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);
  assign take          = s_axis_tvalid && s_axis_tready;

  aet_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .char_i  (s_axis_tdata[CHAR_BITS-1:0]),
    .end_i   (s_axis_tlast),
    .tok0_o  (tok0),
    .tok1_o  (tok1),
    .count_o (count)
  );

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (pop) begin
      head_d = tail_q;
      cnt_d  = cnt_q - 2'd1;
    end
    if (take) begin
      head_d = tok0;
      tail_d = tok1;
      cnt_d  = count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign m_axis_tdata = {(OUT_DATA_BITS - OUT_RAW_BITS)'(0),
                         head_q.line, head_q.value, head_q.kind};
  assign m_axis_tlast = head_q.last;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result slot count out of range");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("second item of a run missing");

  a_one_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> m_axis_tlast)
    else $error("lone result not marked last");

  a_bad_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_q.kind == KIND_BAD) |=> !m_axis_tvalid)
    else $error("output after error token");

endmodule

// ----- verif/arith_expression_tokenizer_test.sv -----
// self-checking testbench for the arithmetic expression tokenizer stream block
// drives character items, predicts tokens in a local scanner model, checks each result item
// depends on aet_pkg and arith_expression_tokenizer
`timescale 1ns / 100ps

module arith_expression_tokenizer_test;
  import aet_pkg::*;

  localparam int N_RANDOM    = 1300;
  localparam int QUIET_ITEMS = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int N_OPEN      = 27;
  localparam int N_ROWS      = 34;

  localparam longint unsigned VMAX = (64'd1 << VALUE_BITS) - 1;

  localparam logic [CHAR_BITS-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_VT      = 8'h0B;
  localparam logic [CHAR_BITS-1:0] CH_FF      = 8'h0C;
  localparam logic [CHAR_BITS-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_BITS-1:0] CH_HIGH    = 8'h80;
  localparam logic [CHAR_BITS-1:0] CH_ALL1    = 8'hFF;

  localparam logic [CHAR_BITS-1:0] OPS [4]    = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  localparam logic [CHAR_BITS-1:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};

  typedef struct {
    logic [CHAR_BITS-1:0] ch;
    logic                 eoi;
    bit                   typed;
    int                   n;
    token_t               t0;
    token_t               t1;
  } stim_row_t;

  localparam token_t NO_TOK = '0;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;   // char_code
  logic                     s_axis_tlast;   // end_of_input
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;   // token_kind, token_value, line_number
  logic                     m_axis_tlast;   // last_of_run

  arith_expression_tokenizer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // scanner state mirrored from the block
  logic                  num_on   = 1'b0;
  logic [VALUE_BITS-1:0] acc      = '0;
  logic [LINE_BITS-1:0]  line_cnt = LINE_BITS'(1);
  logic                  stopped  = 1'b0;

  token_t pending_tokens [$];
  token_t got_tok;
  token_t want_tok;

  int  n_errors    = 0;
  int  n_items     = 0;
  int  n_tokens    = 0;
  int  n_sat       = 0;
  int  stall_cnt   = 0;
  bit  idle_on     = 1'b1;
  bit  hold_req    = 1'b0;
  int  hold_left   = 0;
  int  rx_gap      = 0;

  function automatic token_t tok(kind_e k, longint unsigned v, logic [LINE_BITS-1:0] ln,
                                 bit lst);
    token_t t;
    t.kind  = k;
    t.value = v[VALUE_BITS-1:0];
    t.line  = ln;
    t.last  = lst;
    return t;
  endfunction

  function automatic logic [CHAR_BITS-1:0] dig(int n);
    return CH_ZERO + CHAR_BITS'(n);
  endfunction

  stim_row_t dir_tab [N_ROWS] = '{
    '{CH_PLUS,  1'b0, 1'b1, 1, tok(KIND_PLUS, 0, 1, 1), NO_TOK},
    '{CH_MINUS, 1'b0, 1'b1, 1, tok(KIND_MINUS, 0, 1, 1), NO_TOK},
    '{CH_STAR,  1'b0, 1'b1, 1, tok(KIND_STAR, 0, 1, 1), NO_TOK},
    '{CH_SLASH, 1'b0, 1'b1, 1, tok(KIND_SLASH, 0, 1, 1), NO_TOK},
    '{CH_ALL1,  1'b1, 1'b1, 1, tok(KIND_END, 0, 1, 1), NO_TOK},
    '{dig(0),   1'b0, 1'b1, 0, NO_TOK, NO_TOK},
    '{CH_PLUS,  1'b0, 1'b1, 2, tok(KIND_INT, 0, 1, 0), tok(KIND_PLUS, 0, 1, 1)},
    // largest value that still fits, then two digits that saturate it
    '{dig(2), 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{dig(1), 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{dig(4), 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{dig(7), 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{dig(4), 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{dig(8), 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{dig(3), 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{dig(6), 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{dig(4), 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{dig(7), 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{dig(0), 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{dig(5), 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{CH_NL,    1'b0, 1'b1, 1, tok(KIND_INT, VMAX, 1, 1), NO_TOK},
    '{CH_TAB,   1'b0, 1'b1, 0, NO_TOK, NO_TOK},
    '{CH_SPACE, 1'b0, 1'b1, 0, NO_TOK, NO_TOK},
    '{dig(3),   1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    // newline ends a number: token carries the line before the count moves
    '{CH_NL,    1'b0, 1'b1, 1, tok(KIND_INT, 3, 2, 1), NO_TOK},
    '{dig(9),   1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{CH_NINE,  1'b1, 1'b1, 2, tok(KIND_INT, 9, 3, 0), tok(KIND_END, 0, 3, 1)},
    '{CH_NUL,   1'b1, 1'b1, 1, tok(KIND_END, 0, 3, 1), NO_TOK},
    // closing rows: a pending number, the halting byte, then items that are ignored
    '{dig(4),     1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{dig(2),     1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{CH_NUL,     1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{CH_PERCENT, 1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{CH_HIGH,    1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{CH_ALL1,    1'b0, 1'b0, 0, NO_TOK, NO_TOK},
    '{CH_ALL1,    1'b1, 1'b0, 0, NO_TOK, NO_TOK}
  };

  // tokens caused by one accepted item, with the scanner state advanced
  function automatic void lex_char(input logic [CHAR_BITS-1:0] ch, input logic eoi,
                                   output token_t t0, output token_t t1, output int cnt);
    token_t          outs [2];
    longint unsigned a;
    longint unsigned d;
    int              k;
    kind_e           kd;
    bit              is_dig;
    bit              is_blank;
    outs[0]  = '0;
    outs[1]  = '0;
    k        = 0;
    is_dig   = ch >= CH_ZERO && ch <= CH_NINE;
    is_blank = ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
    if (!stopped) begin
      if (!eoi && is_dig) begin
        d = longint'(ch - CH_ZERO);
        a = num_on ? longint'(acc) : 0;
        if (a > (VMAX - d) / 10) a = VMAX;
        else a = a * 10 + d;
        acc    = a[VALUE_BITS-1:0];
        num_on = 1'b1;
      end else begin
        if (num_on) begin
          outs[k] = tok(KIND_INT, acc, line_cnt, 0);
          k++;
          num_on = 1'b0;
          acc    = '0;
        end
        if (eoi) begin
          outs[k] = tok(KIND_END, 0, line_cnt, 0);
          k++;
        end else if (is_blank) begin
          if (ch == CH_NL) line_cnt = line_cnt + 1'b1;
        end else begin
          case (ch)
            CH_PLUS:  kd = KIND_PLUS;
            CH_MINUS: kd = KIND_MINUS;
            CH_STAR:  kd = KIND_STAR;
            CH_SLASH: kd = KIND_SLASH;
            default: begin
              kd      = KIND_BAD;
              stopped = 1'b1;
            end
          endcase
          outs[k] = tok(kd, 0, line_cnt, 0);
          k++;
        end
      end
      if (k > 0) outs[k-1].last = 1'b1;
    end
    t0  = outs[0];
    t1  = outs[1];
    cnt = k;
  endfunction

  task automatic report_mismatch(string msg);
    if (n_errors < 50) $display("%0t ns: mismatch: %s", $time, msg);
    n_errors++;
  endtask

  task automatic send_item(input stim_row_t row);
    token_t p0;
    token_t p1;
    int     cnt;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_DATA_BITS'($urandom);
      s_axis_tlast  <= 1'($urandom);
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.ch;
    s_axis_tlast  <= row.eoi;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    lex_char(row.ch, row.eoi, p0, p1, cnt);
    if (row.typed) begin
      p0  = row.t0;
      p1  = row.t1;
      cnt = row.n;
    end
    if (cnt > 0) pending_tokens.push_back(p0);
    if (cnt > 1) pending_tokens.push_back(p1);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  always #5 clk_i = ~clk_i;

  // receiver: random stalls plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (rx_gap > 0) begin
        m_axis_tready <= 1'b0;
        rx_gap--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        rx_gap = $urandom_range(1, 9) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker and stall watchdog
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      got_tok.kind  = kind_e'(m_axis_tdata[KIND_BITS-1:0]);
      got_tok.value = m_axis_tdata[KIND_BITS +: VALUE_BITS];
      got_tok.line  = m_axis_tdata[KIND_BITS+VALUE_BITS +: LINE_BITS];
      got_tok.last  = m_axis_tlast;
      n_tokens++;
      if (got_tok.kind == KIND_INT && got_tok.value == VMAX) n_sat++;
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("token kind %0d value %0d with none expected",
                                  got_tok.kind, got_tok.value));
      end else begin
        want_tok = pending_tokens.pop_front();
        if (got_tok.kind != want_tok.kind)
          report_mismatch($sformatf("token_kind got %0d want %0d",
                                    got_tok.kind, want_tok.kind));
        if (got_tok.value != want_tok.value)
          report_mismatch($sformatf("token_value got %0d want %0d",
                                    got_tok.value, want_tok.value));
        if (got_tok.line != want_tok.line)
          report_mismatch($sformatf("line_number got %0d want %0d",
                                    got_tok.line, want_tok.line));
        if (got_tok.last != want_tok.last)
          report_mismatch($sformatf("last_of_run got %0d want %0d",
                                    got_tok.last, want_tok.last));
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("arith_expression_tokenizer_test failed");
      $finish;
    end
  end

  initial begin
    stim_row_t            r;
    logic [CHAR_BITS-1:0] ch;
    logic                 eoi;
    int                   digit_run;
    int                   sel;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    digit_run     = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_OPEN; i++) send_item(dir_tab[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) hold_req = 1'b1;
      if (i == N_RANDOM / 2) wait_drained();
      if (i == N_RANDOM - QUIET_ITEMS) idle_on = 1'b0;
      eoi = 1'b0;
      if (digit_run > 0) begin
        ch = dig($urandom_range(0, 9));
        digit_run--;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          // mostly short numbers, now and then a long one that can saturate
          digit_run = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 3);
          ch = dig($urandom_range(0, 9));
        end else if (sel < 60) begin
          ch = OPS[$urandom_range(0, 3)];
        end else if (sel < 70) begin
          ch = CH_NL;
        end else if (sel < 92) begin
          ch = BLANKS[$urandom_range(0, 5)];
        end else begin
          ch  = CHAR_BITS'($urandom_range(0, 255));
          eoi = 1'b1;
        end
      end
      r = '{ch, eoi, 1'b0, 0, NO_TOK, NO_TOK};
      send_item(r);
    end

    for (int i = N_OPEN; i < N_ROWS; i++) send_item(dir_tab[i]);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("sent %0d items, checked %0d tokens, %0d of them saturated integers",
             n_items, n_tokens, n_sat);
    $display("scanner reached line %0d and ended halted on an unrecognized byte", line_cnt);
    if (n_errors == 0) begin
      $display("arith_expression_tokenizer_test passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("arith_expression_tokenizer_test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/aet_pkg.sv
design/aet_scan.sv
design/arith_expression_tokenizer.sv
verif/arith_expression_tokenizer_test.sv
